@@ rtl/sfr_pkg.sv @@
// ---------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the stream find-and-replace block.
// ---------------------------------------------------------------------------
package sfr_pkg;

   localparam int PATTERN_MAX_DEF     = 8;
   localparam int REPLACEMENT_MAX_DEF = 8;
   localparam int WIN_DEPTH           = 8;
   localparam int WIN_IDX_W           = $clog2(WIN_DEPTH);
   localparam int QUEUE_DEPTH         = 4;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int LEN_W       = 4;
   localparam int COUNT_W     = 16;

   // register indexes of the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_BYTES      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_BYTES  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_LENGTH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACE_LIMIT      = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LIMIT_ENABLED      = 3'd5;

   // input command codes
   localparam logic CMD_BYTE  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] in_byte;
   } sfr_req_type;

   typedef struct packed {
      logic [7:0]         out_byte;
      logic               byte_valid;
      logic               run_last;
      logic               stream_done;
      logic [COUNT_W-1:0] replacements_made;
   } sfr_rsp_type;

   // one queued action: a run of bytes, optionally followed by a done item
   typedef struct packed {
      logic [8*WIN_DEPTH-1:0] data;
      logic [LEN_W-1:0]       nbytes;
      logic                   has_done;
      logic [COUNT_W-1:0]     count;
   } sfr_act_type;

endpackage

@@ rtl/sfr_front.sv @@
// ---------------------------------------------------------------------------
// sfr_front
// Configuration registers, pending window and match decision; turns each
// accepted item into at most one queued action.
// ---------------------------------------------------------------------------
module sfr_front #(
   parameter int PATTERN_MAX     = sfr_pkg::PATTERN_MAX_DEF,
   parameter int REPLACEMENT_MAX = sfr_pkg::REPLACEMENT_MAX_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  sfr_pkg::sfr_req_type                req_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                q_push,
   input  logic                                q_full,
   output sfr_pkg::sfr_act_type                q_act
);
   import sfr_pkg::*;

   logic [8*PATTERN_MAX-1:0]     pat_bytes_ff;
   logic [LEN_W-1:0]             pat_len_ff;
   logic [8*REPLACEMENT_MAX-1:0] rep_bytes_ff;
   logic [LEN_W-1:0]             rep_len_ff;
   logic [COUNT_W-1:0]           limit_ff;
   logic                         limit_en_ff;

   logic [7:0]         win_ff [WIN_DEPTH];
   logic [7:0]         win_in [WIN_DEPTH];
   logic [LEN_W-1:0]   fill_ff, fill_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic [7:0]             aw [WIN_DEPTH];
   logic [LEN_W-1:0]       fill_a;
   logic [LEN_W-1:0]       plen, rlen, drop;
   logic                   allowed, hit, match, ready_cmp;
   logic                   accept;
   logic [8*WIN_DEPTH-1:0] rep_ext, win_pack;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;
   assign accept    = req_push && !q_full;

   assign plen = (pat_len_ff > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_ff;
   assign rlen = (rep_len_ff > LEN_W'(REPLACEMENT_MAX)) ? LEN_W'(REPLACEMENT_MAX)
                                                        : rep_len_ff;
   assign allowed = !limit_en_ff || (count_ff < limit_ff);
   assign fill_a  = fill_ff + LEN_W'(1);

   always_comb begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
         aw[i] = (fill_ff == LEN_W'(i)) ? req_data.in_byte : win_ff[i];
         win_pack[8*i +: 8] = win_ff[i];
      end
      rep_ext = '0;
      rep_ext[8*REPLACEMENT_MAX-1:0] = rep_bytes_ff;
   end

   // parallel compare of the leading pattern bytes
   always_comb begin
      hit = 1'b1;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (LEN_W'(i) < plen && aw[i] != pat_bytes_ff[8*i +: 8]) begin
            hit = 1'b0;
         end
      end
   end

   assign ready_cmp = (fill_a >= plen);
   assign match     = ready_cmp && (plen != '0) && allowed && hit;
   assign drop      = !ready_cmp ? '0 : (match ? plen : LEN_W'(1));

   always_comb begin
      logic [LEN_W:0] idx;
      idx = '0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         idx = (LEN_W+1)'(i) + {1'b0, drop};
         if (idx < (LEN_W+1)'(WIN_DEPTH)) begin
            win_in[i] = aw[idx[WIN_IDX_W-1:0]];
         end else begin
            win_in[i] = 8'h00;
         end
      end
   end

   always_comb begin
      fill_in  = fill_ff;
      count_in = count_ff;
      q_push   = 1'b0;
      q_act    = '0;
      if (accept) begin
         if (req_data.cmd == CMD_FLUSH) begin
            fill_in        = '0;
            count_in       = '0;
            q_push         = 1'b1;
            q_act.data     = win_pack;
            q_act.nbytes   = fill_ff;
            q_act.has_done = 1'b1;
            q_act.count    = count_ff;
         end else begin
            fill_in = fill_a - drop;
            if (match) begin
               if (count_ff != '1) begin
                  count_in = count_ff + COUNT_W'(1);
               end
               // a zero-length replacement yields no result at all
               q_push       = (rlen != '0);
               q_act.data   = rep_ext;
               q_act.nbytes = rlen;
            end else if (ready_cmp) begin
               q_push          = 1'b1;
               q_act.data[7:0] = aw[0];
               q_act.nbytes    = LEN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         count_ff     <= '0;
         pat_bytes_ff <= '0;
         pat_len_ff   <= '0;
         rep_bytes_ff <= '0;
         rep_len_ff   <= '0;
         limit_ff     <= '0;
         limit_en_ff  <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         count_ff <= count_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_PATTERN_BYTES:      pat_bytes_ff <= csr_wdata[8*PATTERN_MAX-1:0];
               CSR_PATTERN_LENGTH:     pat_len_ff   <= csr_wdata[LEN_W-1:0];
               CSR_REPLACEMENT_BYTES:  rep_bytes_ff <= csr_wdata[8*REPLACEMENT_MAX-1:0];
               CSR_REPLACEMENT_LENGTH: rep_len_ff   <= csr_wdata[LEN_W-1:0];
               CSR_REPLACE_LIMIT:      limit_ff     <= csr_wdata[COUNT_W-1:0];
               CSR_LIMIT_ENABLED:      limit_en_ff  <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_data.cmd == CMD_BYTE) begin
         win_ff <= win_in;
      end
   end

endmodule

@@ rtl/sfr_queue.sv @@
// ---------------------------------------------------------------------------
// sfr_queue
// Short action queue between the front and the back part.
// ---------------------------------------------------------------------------
module sfr_queue #(
   parameter int DEPTH = sfr_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sfr_pkg::sfr_act_type push_act,
   output logic                 full,
   input  logic                 pop,
   output sfr_pkg::sfr_act_type head_act,
   output logic                 empty
);
   import sfr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   sfr_act_type      mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_act = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_act;
      end
   end

endmodule

@@ rtl/sfr_back.sv @@
// ---------------------------------------------------------------------------
// sfr_back
// Expands queued actions into result items, one per cycle while the result
// stage is empty or being popped, into a registered result stage.
// ---------------------------------------------------------------------------
module sfr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  sfr_pkg::sfr_act_type head_act,
   input  logic                 q_empty,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output sfr_pkg::sfr_rsp_type rsp_data
);
   import sfr_pkg::*;

   logic [LEN_W-1:0] pos_ff, pos_in;
   logic             out_valid_ff, out_valid_in;
   sfr_rsp_type      out_ff, out_in;
   logic             in_bytes, last, advance;

   assign in_bytes = (pos_ff < head_act.nbytes);
   assign last     = in_bytes ? ((pos_ff == head_act.nbytes - LEN_W'(1)) && !head_act.has_done)
                              : 1'b1;
   assign advance  = !q_empty && (!out_valid_ff || rsp_pop);
   assign q_pop    = advance && last;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      pos_in       = pos_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = '0;
         out_in.run_last = last;
         if (in_bytes) begin
            out_in.out_byte   = head_act.data[{pos_ff[WIN_IDX_W-1:0], 3'b000} +: 8];
            out_in.byte_valid = 1'b1;
         end else begin
            out_in.stream_done       = 1'b1;
            out_in.replacements_made = head_act.count;
         end
         pos_in = last ? '0 : pos_ff + LEN_W'(1);
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

@@ rtl/stream_find_and_replace.sv @@
// An accepted item's results pass through the action queue, then the registered result stage.
// Throughput: one item accepted per cycle while the action queue has room; the back
// part emits one result per cycle while the result register is empty or being popped.
// Reset (synchronous) empties the window, counter, action queue and result register
// and clears all configuration registers to zero; no clearing pass is needed.
// ---------------------------------------------------------------------------
// stream_find_and_replace
// Byte stream find-and-replace with optional replacement limit; front part
// decides per item, back part serializes the resulting bytes and done items.
// ---------------------------------------------------------------------------
module stream_find_and_replace #(
   parameter int PATTERN_MAX     = sfr_pkg::PATTERN_MAX_DEF,
   parameter int REPLACEMENT_MAX = sfr_pkg::REPLACEMENT_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  sfr_pkg::sfr_req_type            req_data,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output sfr_pkg::sfr_rsp_type            rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sfr_pkg::*;

   logic        q_push, q_full, q_pop, q_empty;
   sfr_act_type q_act, head_act;

   sfr_front #(
      .PATTERN_MAX     (PATTERN_MAX),
      .REPLACEMENT_MAX (REPLACEMENT_MAX)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_push    (q_push),
      .q_full    (q_full),
      .q_act     (q_act)
   );

   sfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_act (q_act),
      .full     (q_full),
      .pop      (q_pop),
      .head_act (head_act),
      .empty    (q_empty)
   );

   sfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_act  (head_act),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/sfr_checker.sv @@
// ---------------------------------------------------------------------------
// sfr_checker
// Port-level checks of the find-and-replace block, bound to the top level.
// ---------------------------------------------------------------------------
module sfr_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_empty,
   input logic                 rsp_pop,
   input sfr_pkg::sfr_rsp_type rsp_data
);
   import sfr_pkg::*;

   // no result is offered right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("result offered right after reset");

   // a waiting item holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting item changed before pop");

   // done item closes its run and carries no byte
   a_done_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.stream_done) |-> (rsp_data.run_last && !rsp_data.byte_valid))
      else $error("malformed done item");

   // byte items carry no count
   a_byte_shape: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.byte_valid)
         |-> (rsp_data.replacements_made == '0 && !rsp_data.stream_done))
      else $error("malformed byte item");

   // every item is either a byte or a done item
   a_item_kind: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.byte_valid || rsp_data.stream_done))
      else $error("item is neither byte nor done");

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (.*);
